/* src/acm_coefficient_unpacker_unit_defines.svh */
// Assertion macros for the coefficient unpacker.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef ACM_COEFFICIENT_UNPACKER_UNIT_DEFINES_SVH
`define ACM_COEFFICIENT_UNPACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ACU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ACU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/acu_pkg.sv */
// Shared types, constants and decode functions of the coefficient unpacker.
// No dependencies.
package acu_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_LOG2    = $clog2(MAX_COLUMNS);
    localparam int MAX_RESULTS = 16;

    localparam logic REG_LEVEL_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT   = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
        logic flush;
    } acu_cmd_t;

    typedef struct packed {
        logic halted;
        logic dec_avail;
        logic dec_ok;
        logic dec_halt;
        logic dec_list;
        logic emit_ok;
        logic emit_done;
        logic flush_ok;
        logic pend_valid;
    } acu_status_t;

    typedef struct packed {
        logic [15:0] value;
        logic [11:0] row;
        logic [9:0]  column;
        logic        zero_column;
        logic        block_last;
        logic        error;
    } acu_result_t;

    typedef struct packed {
        logic [4:0]         take;
        logic [1:0]         cnt;
        logic signed [16:0] lv0;
        logic signed [16:0] lv1;
        logic signed [16:0] lv2;
    } acu_fill_t;

    function automatic logic [4:0] fill_need(input logic [4:0] k);
        logic [4:0] r;
        if (k >= 5'd3 && k <= 5'd16) r = k;
        else begin
            case (k)
                5'd17: r = 5'd3;
                5'd18: r = 5'd2;
                5'd19: r = 5'd5;
                5'd20: r = 5'd4;
                5'd21: r = 5'd3;
                5'd22: r = 5'd7;
                5'd23: r = 5'd5;
                5'd24: r = 5'd4;
                5'd26: r = 5'd5;
                5'd27: r = 5'd4;
                5'd29: r = 5'd7;
                default: r = 5'd1;
            endcase
        end
        return r;
    endfunction

    function automatic logic [1:0] fill_room(input logic [4:0] k);
        logic [1:0] r;
        case (k)
            5'd19, 5'd22: r = 2'd3;
            5'd17, 5'd20, 5'd23, 5'd26, 5'd29: r = 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic is_reserved(input logic [4:0] s);
        return s == 5'd1 || s == 5'd2 || s == 5'd25 || s == 5'd28
            || s == 5'd30 || s == 5'd31;
    endfunction

    // Quotient by counting independent compares against multiples of d.
    function automatic logic [3:0] quot(input logic [6:0] c, input logic [6:0] d);
        logic [3:0] q;
        q = 4'd0;
        for (int i = 1; i <= 11; i++) begin
            if ({4'd0, c} >= 11'(d) * 11'(i)) q = q + 4'd1;
        end
        return q;
    endfunction

    function automatic acu_fill_t fill_decode(input logic [4:0] k, input logic [15:0] b);
        acu_fill_t   f;
        logic [16:0] mask;
        logic [16:0] code;
        logic [16:0] half;
        logic [6:0]  c;
        logic [3:0]  q1;
        logic [3:0]  q2;
        logic [6:0]  r1;
        logic [6:0]  r2;
        logic [2:0]  qq;
        f    = '0;
        mask = (17'd1 << k) - 17'd1;
        code = {1'b0, b} & mask;
        half = 17'd1 << (k - 5'd1);
        c    = b[6:0];
        q1   = 4'd0;
        q2   = 4'd0;
        r1   = 7'd0;
        r2   = 7'd0;
        qq   = 3'd0;
        if (k >= 5'd3 && k <= 5'd16) begin
            f.take = k;
            f.cnt  = 2'd1;
            f.lv0  = signed'(code - half);
        end else if ((k == 5'd17 || k == 5'd20 || k == 5'd23 || k == 5'd26) && !b[0]) begin
            f.take = 5'd1;
            f.cnt  = 2'd2;
        end else if ((k == 5'd17 || k == 5'd20 || k == 5'd23 || k == 5'd26) && !b[1]) begin
            f.take = 5'd2;
            f.cnt  = 2'd1;
        end else if ((k == 5'd18 || k == 5'd21 || k == 5'd24 || k == 5'd27) && !b[0]) begin
            f.take = 5'd1;
            f.cnt  = 2'd1;
        end else begin
            f.cnt = 2'd1;
            case (k)
                5'd17: begin
                    f.take = 5'd3;
                    f.lv0  = b[2] ? 17'sd1 : -17'sd1;
                end
                5'd18: begin
                    f.take = 5'd2;
                    f.lv0  = b[1] ? 17'sd1 : -17'sd1;
                end
                5'd19: begin
                    f.take = 5'd5;
                    f.cnt  = 2'd3;
                    c      = {2'd0, b[4:0]};
                    q1     = quot(c, 7'd9);
                    r1     = c - 7'd9 * 7'(q1);
                    q2     = quot(r1, 7'd3);
                    r2     = r1 - 7'd3 * 7'(q2);
                    f.lv0  = 17'(r2) - 17'sd1;
                    f.lv1  = 17'(q2) - 17'sd1;
                    f.lv2  = 17'(q1) - 17'sd1;
                end
                5'd20: begin
                    f.take = 5'd4;
                    f.lv0  = b[3] ? (b[2] ? 17'sd2 : 17'sd1) : (b[2] ? -17'sd1 : -17'sd2);
                end
                5'd21: begin
                    f.take = 5'd3;
                    f.lv0  = b[2] ? (b[1] ? 17'sd2 : 17'sd1) : (b[1] ? -17'sd1 : -17'sd2);
                end
                5'd22: begin
                    f.take = 5'd7;
                    f.cnt  = 2'd3;
                    q1     = quot(c, 7'd25);
                    r1     = c - 7'd25 * 7'(q1);
                    q2     = quot(r1, 7'd5);
                    r2     = r1 - 7'd5 * 7'(q2);
                    f.lv0  = 17'(r2) - 17'sd2;
                    f.lv1  = 17'(q2) - 17'sd2;
                    f.lv2  = 17'(q1) - 17'sd2;
                end
                5'd23: begin
                    if (!b[2]) begin
                        f.take = 5'd4;
                        f.lv0  = b[3] ? 17'sd1 : -17'sd1;
                    end else begin
                        f.take = 5'd5;
                        qq     = {1'b0, b[4:3]};
                        if (qq >= 3'd2) qq = qq + 3'd3;
                        f.lv0  = 17'(qq) - 17'sd3;
                    end
                end
                5'd24: begin
                    if (!b[1]) begin
                        f.take = 5'd3;
                        f.lv0  = b[2] ? 17'sd1 : -17'sd1;
                    end else begin
                        f.take = 5'd4;
                        qq     = {1'b0, b[3:2]};
                        if (qq >= 3'd2) qq = qq + 3'd3;
                        f.lv0  = 17'(qq) - 17'sd3;
                    end
                end
                5'd26: begin
                    f.take = 5'd5;
                    f.lv0  = 17'(b[4:2]) + ((b[4:2] >= 3'd4) ? 17'sd1 : 17'sd0) - 17'sd4;
                end
                5'd27: begin
                    f.take = 5'd4;
                    f.lv0  = 17'(b[3:1]) + ((b[3:1] >= 3'd4) ? 17'sd1 : 17'sd0) - 17'sd4;
                end
                5'd29: begin
                    f.take = 5'd7;
                    f.cnt  = 2'd2;
                    q1     = quot(c, 7'd11);
                    r1     = c - 7'd11 * 7'(q1);
                    f.lv0  = 17'(r1) - 17'sd5;
                    f.lv1  = 17'(q1) - 17'sd5;
                end
                default: begin
                    f.take = 5'd1;
                    f.cnt  = 2'd0;
                end
            endcase
        end
        return f;
    endfunction

endpackage

/* src/acm_coefficient_unpacker_unit.sv */
// Top level of the coefficient unpacker: controller plus datapath.
// Depends on acu_pkg, acu_ctrl, acu_datapath and the defines header.
//
// Takes one compressed byte per item into a 32-bit LSB-first bit window and
// decodes block headers, column fill selectors and level codes from it,
// producing at most one coefficient result per cycle. A byte is accepted only
// when the block is idle; it is then loaded, each header field, selector or
// fill code is decoded in its own step, each level a fill code yields is
// emitted in turn, the window is found short and the burst is closed; a byte
// yields at most sixteen results, and the output can stall any step that
// produces a result. Zero-column and error results ride on their selector
// step. The last result a byte causes is marked with burst_last; a finished
// result may wait at the output while the next byte is accepted. A reserved
// selector yields one error result and the block then drops every byte until
// reset. Write the configuration registers only while idle.
module acm_coefficient_unpacker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [12:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        stream_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [15:0] value,
    output logic [11:0]       row,
    output logic [9:0]        column,
    output logic              zero_column,
    output logic              block_last,
    output logic              error,
    output logic              burst_last
);

`include "acm_coefficient_unpacker_unit_defines.svh"

    acu_pkg::acu_cmd_t    cmd;
    acu_pkg::acu_status_t st;
    acu_pkg::acu_result_t res;

    // sequence the item through load, decode, emit and flush
    acu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // hold the window, indexes and the result registers
    acu_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stream_byte    (stream_byte),
        .cmd            (cmd),
        .st             (st),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_res        (res),
        .out_burst_last (burst_last)
    );

    assign value       = signed'(res.value);
    assign row         = res.row;
    assign column      = res.column;
    assign zero_column = res.zero_column;
    assign block_last  = res.block_last;
    assign error       = res.error;

    // a new item only enters with no result held back from the last one
    `ACU_ASSERT_NOW(a_idle_no_pend, in_ready, !st.pend_valid,
                    "item accepted with a result still pending")
    // an error result is only shown once the block has halted
    `ACU_ASSERT_NOW(a_error_halted, out_valid && error, st.halted,
                    "error result without halt")
    // closing a burst always drains the pending result
    `ACU_ASSERT_NEXT(a_flush_drains, cmd.flush, !st.pend_valid,
                     "pending result left after flush")

endmodule

/* src/acu_ctrl.sv */
// Controller of the coefficient unpacker: sequences load, decode, emit, flush.
// Depends on acu_pkg.
module acu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  acu_pkg::acu_status_t st,
    output acu_pkg::acu_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!st.halted) state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!st.dec_avail) state_next = S_FLUSH;
                else if (st.dec_ok)
                begin
                    cmd.step = 1'b1;
                    if (st.dec_halt) state_next = S_FLUSH;
                    else if (st.dec_list) state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    if (st.emit_done) state_next = S_DECODE;
                end
            end
            S_FLUSH:
            begin
                if (st.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

endmodule

/* src/acu_datapath.sv */
// Datapath of the coefficient unpacker: bit window, indexes, level list,
// pending result and output register. Depends on acu_pkg.
module acu_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [12:0]          cfg_data,
    input  logic [7:0]           stream_byte,
    input  acu_pkg::acu_cmd_t    cmd,
    output acu_pkg::acu_status_t st,
    input  logic                 out_ready,
    output logic                 out_valid,
    output acu_pkg::acu_result_t out_res,
    output logic                 out_burst_last
);

    localparam logic [1:0] PH_POWER  = 2'd0;
    localparam logic [1:0] PH_STEP   = 2'd1;
    localparam logic [1:0] PH_SELECT = 2'd2;
    localparam logic [1:0] PH_FILL   = 2'd3;

    logic [3:0]  level_count_reg;
    logic [12:0] row_count_reg;
    logic [31:0] window_reg, window_next;
    logic [5:0]  count_reg, count_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] step_reg, step_next;
    logic [9:0]  col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [4:0]  kind_reg, kind_next;
    logic        halted_reg, halted_next;
    logic [4:0]  n_reg, n_next;
    logic signed [16:0] lv_reg [3];
    logic signed [16:0] lv_next [3];
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  cnt_reg, cnt_next;
    acu_pkg::acu_result_t pend_reg;
    logic        pend_valid_reg;
    acu_pkg::acu_result_t out_reg;
    logic        out_valid_reg;
    logic        out_bl_reg;

    logic [10:0] ncols;
    logic [12:0] nrows;
    logic        col_end;
    logic        row_end;
    logic [4:0]  sel;
    logic        sel_res;
    acu_pkg::acu_fill_t fill;
    logic        out_free;
    logic        slot_ok;
    logic [5:0]  take;
    logic        produce;
    acu_pkg::acu_result_t new_res;
    logic signed [16:0] level;
    logic [31:0] prod;

    assign ncols = (level_count_reg >= 4'(acu_pkg::COL_LOG2))
                 ? 11'(acu_pkg::MAX_COLUMNS) : (11'd1 << level_count_reg);
    assign nrows = (row_count_reg == 13'd0) ? 13'd1
                 : (row_count_reg > 13'(acu_pkg::MAX_ROWS)) ? 13'(acu_pkg::MAX_ROWS)
                 : row_count_reg;
    assign col_end = ({1'b0, col_reg} + 11'd1) >= ncols;
    assign row_end = ({1'b0, row_reg} + 13'd1) >= nrows;

    assign sel     = window_reg[4:0];
    assign sel_res = (sel == 5'd0) || acu_pkg::is_reserved(sel);
    assign fill    = acu_pkg::fill_decode(kind_reg, window_reg[15:0]);

    assign out_free = !out_valid_reg || out_ready;
    assign slot_ok  = !pend_valid_reg || out_free;

    assign level = lv_reg[idx_reg];
    assign prod  = 32'(level[15:0]) * 32'(step_reg);

    always_comb
    begin
        st            = '0;
        st.halted     = halted_reg;
        st.pend_valid = pend_valid_reg;
        st.emit_ok    = slot_ok;
        st.flush_ok   = slot_ok;
        st.emit_done  = row_end || ({1'b0, idx_reg} + 3'd1 >= {1'b0, cnt_reg});
        case (phase_reg)
            PH_POWER:  st.dec_avail = count_reg >= 6'd4;
            PH_STEP:   st.dec_avail = count_reg >= 6'd16;
            PH_SELECT: st.dec_avail = (count_reg >= 6'd5)
                                      && (n_reg < 5'(acu_pkg::MAX_RESULTS));
            default:   st.dec_avail = (count_reg >= {1'b0, acu_pkg::fill_need(kind_reg)})
                                      && ({1'b0, n_reg} + 6'(acu_pkg::fill_room(kind_reg))
                                          <= 6'(acu_pkg::MAX_RESULTS));
        endcase
        st.dec_ok   = st.dec_avail && (!(phase_reg == PH_SELECT && sel_res) || slot_ok);
        st.dec_halt = (phase_reg == PH_SELECT) && acu_pkg::is_reserved(sel);
        st.dec_list = (phase_reg == PH_FILL) && (fill.cnt != 2'd0);
    end

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        kind_next   = kind_reg;
        halted_next = halted_reg;
        n_next      = n_reg;
        lv_next     = lv_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        take        = 6'd0;
        produce     = 1'b0;
        new_res     = '0;
        new_res.column = col_reg;

        if (cmd.load && !halted_reg)
        begin
            n_next = 5'd0;
            if (count_reg <= 6'd24)
            begin
                window_next = window_reg | ({24'd0, stream_byte} << count_reg[4:0]);
                count_next  = count_reg + 6'd8;
            end
        end

        if (cmd.step)
        begin
            case (phase_reg)
                PH_POWER:
                begin
                    take       = 6'd4;
                    phase_next = PH_STEP;
                end
                PH_STEP:
                begin
                    take       = 6'd16;
                    step_next  = window_reg[15:0];
                    col_next   = 10'd0;
                    row_next   = 12'd0;
                    phase_next = PH_SELECT;
                end
                PH_SELECT:
                begin
                    take      = 6'd5;
                    kind_next = sel;
                    row_next  = 12'd0;
                    if (sel == 5'd0)
                    begin
                        produce             = 1'b1;
                        new_res.zero_column = 1'b1;
                        new_res.block_last  = col_end;
                        n_next              = n_reg + 5'd1;
                        // advance to the next column or close the block
                        if (col_end)
                        begin
                            col_next   = 10'd0;
                            phase_next = PH_POWER;
                        end
                        else col_next = col_reg + 10'd1;
                    end
                    else if (acu_pkg::is_reserved(sel))
                    begin
                        produce       = 1'b1;
                        new_res.error = 1'b1;
                        n_next        = n_reg + 5'd1;
                        halted_next   = 1'b1;
                    end
                    else phase_next = PH_FILL;
                end
                default:
                begin
                    take       = 6'(fill.take);
                    lv_next[0] = fill.lv0;
                    lv_next[1] = fill.lv1;
                    lv_next[2] = fill.lv2;
                    cnt_next   = fill.cnt;
                    idx_next   = 2'd0;
                end
            endcase
            window_next = window_next >> take;
            count_next  = count_next - take;
        end

        if (cmd.emit)
        begin
            produce            = 1'b1;
            new_res.value      = prod[15:0];
            new_res.row        = row_reg;
            new_res.block_last = row_end && col_end;
            n_next             = n_reg + 5'd1;
            idx_next           = idx_reg + 2'd1;
            if (row_end)
            begin
                // column done: drop any levels left in the list
                row_next = 12'd0;
                if (col_end)
                begin
                    col_next   = 10'd0;
                    phase_next = PH_POWER;
                end
                else
                begin
                    col_next   = col_reg + 10'd1;
                    phase_next = PH_SELECT;
                end
            end
            else row_next = row_reg + 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= 4'd0;
            row_count_reg   <= 13'd1;
            window_reg      <= 32'd0;
            count_reg       <= 6'd0;
            phase_reg       <= PH_POWER;
            step_reg        <= 16'd0;
            col_reg         <= 10'd0;
            row_reg         <= 12'd0;
            kind_reg        <= 5'd0;
            halted_reg      <= 1'b0;
            n_reg           <= 5'd0;
            idx_reg         <= 2'd0;
            cnt_reg         <= 2'd0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == acu_pkg::REG_LEVEL_COUNT) level_count_reg <= cfg_data[3:0];
                else                                       row_count_reg   <= cfg_data;
            end
            window_reg <= window_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            kind_reg   <= kind_next;
            halted_reg <= halted_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;

            if (produce) pend_valid_reg <= 1'b1;
            else if (cmd.flush && pend_valid_reg) pend_valid_reg <= 1'b0;

            // move the pending result out, else drop the one just taken
            if ((produce || cmd.flush) && pend_valid_reg) out_valid_reg <= 1'b1;
            else if (out_ready)                           out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lv_reg <= lv_next;
        if (produce)
        begin
            pend_reg <= new_res;
            if (pend_valid_reg)
            begin
                out_reg    <= pend_reg;
                out_bl_reg <= 1'b0;
            end
        end
        else if (cmd.flush && pend_valid_reg)
        begin
            out_reg    <= pend_reg;
            out_bl_reg <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_res        = out_reg;
    assign out_burst_last = out_bl_reg;

endmodule
